// ===== sv/assert_macros.svh =====
// assertion macros shared by the lux core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// when cond holds, prop holds in the next cycle
`define ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/lsal_pkg.sv =====
// package with widths, register codes and shared types of the lux core
`default_nettype none

package lsal_pkg;

   localparam int COUNT_W    = 16;
   localparam int FS_W       = 20;
   localparam int DIV_W      = 17;
   localparam int CORR_W     = 8;
   localparam int LUX_W      = 28;
   localparam int RANGE_W    = 2;
   localparam int NUM_RANGES = 4;
   localparam int PROD_W     = FS_W + COUNT_W;
   localparam int MUL_A_W    = LUX_W;
   localparam int MUL_B_W    = COUNT_W;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int STEP_W     = 6;

   localparam logic [LUX_W-1:0]   LUX_MAX     = 28'hFFF_FFFF;
   localparam logic [RANGE_W-1:0] RANGE_LOW   = 2'd0;
   localparam logic [RANGE_W-1:0] RANGE_TOP   = 2'd3;
   localparam logic [FS_W-1:0]    FS0_RESET   = 20'd1000;
   localparam logic [FS_W-1:0]    FS1_RESET   = 20'd4000;
   localparam logic [FS_W-1:0]    FS2_RESET   = 20'd16000;
   localparam logic [FS_W-1:0]    FS3_RESET   = 20'd64000;
   localparam logic [DIV_W-1:0]   DIV_RESET   = 17'd65536;
   localparam logic [CORR_W-1:0]  CORR_RESET  = 8'd10;
   localparam logic [STEP_W-1:0]  LAST_STEP   = 6'(PROD_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FS0     = 3'd0,
      CSR_FS1     = 3'd1,
      CSR_FS2     = 3'd2,
      CSR_FS3     = 3'd3,
      CSR_DIVISOR = 3'd4,
      CSR_CORR    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [NUM_RANGES-1:0][FS_W-1:0] full_scale;
      logic [DIV_W-1:0]                divisor;
      logic [CORR_W-1:0]               corr;
   } lsal_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // clamp a wide lux value to the result field
   function automatic logic [LUX_W-1:0] sat_lux(input logic [PROD_W-1:0] v);
      logic [LUX_W-1:0] r;
      if (v[PROD_W-1:LUX_W] != '0) begin
         r = LUX_MAX;
      end else begin
         r = v[LUX_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/lsal_if.sv =====
// request and response channel interfaces of the lux core
`default_nettype none

interface lsal_req_if import lsal_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] adc_count;

   modport source (output valid, output adc_count, input ready);
   modport sink   (input valid, input adc_count, output ready);
endinterface

interface lsal_rsp_if import lsal_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               remeasure;
   logic [RANGE_W-1:0] active_range;
   logic [LUX_W-1:0]   lux_report;

   modport source (output valid, output remeasure, output active_range, output lux_report,
                   input ready);
   modport sink   (input valid, input remeasure, input active_range, input lux_report,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/light_sensor_autorange_lux_core.sv =====
// top level of the auto-ranging lux core: sequencer, shared multiplier, divider, csr
//
//   channel   direction  handshake            payload
//   req_ch    in         valid / ready        adc_count
//   rsp_ch    out        valid / ready        remeasure, active_range, lux_report
//   csr_*     in         csr_we (no ready)    csr_index, csr_wdata
//
// a transaction runs the multiply, divide, compare and correction steps; a range change
// skips the correction step and a zero divisor skips the divider
// the serial divider produces one quotient bit per cycle over a 36-bit product
// reset is synchronous and active high; it restores the register defaults and range zero
// a new request transaction is taken while the previous response still waits;
// a stalled response holds the block in its final state until the sink takes it
`default_nettype none
`include "assert_macros.svh"

module light_sensor_autorange_lux_core import lsal_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lsal_req_if.sink                   req_ch,
   lsal_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_CMP  = 6'b001000,
      ST_CORR = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [RANGE_W-1:0] range_ff, range_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LUX_W-1:0]   lux_ff, lux_in;
   logic               res_remeasure_ff, res_remeasure_in;
   logic [LUX_W-1:0]   res_lux_ff, res_lux_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_remeasure_ff, rsp_remeasure_in;
   logic [RANGE_W-1:0] rsp_range_ff, rsp_range_in;
   logic [LUX_W-1:0]   rsp_lux_ff, rsp_lux_in;

   lsal_cfg_type       cfg;
   div_sts_type        div_sts;
   logic [PROD_W-1:0]  div_quo;
   logic               div_start;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;
   logic [PROD_W-1:0]  prod;

   logic [FS_W-1:0]    fs_cur;
   logic [FS_W-1:0]    fs_below;
   logic               step_up;
   logic               step_down;
   logic               div_by_zero;

   lsal_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // shared multiplier: full scale times count, then lux times window correction
   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = {{(MUL_A_W-FS_W){1'b0}}, cfg.full_scale[range_ff]};
         mul_b = count_ff;
      end else begin
         mul_a = lux_ff;
         mul_b = {{(MUL_B_W-CORR_W){1'b0}}, cfg.corr};
      end
   end

   assign mul_p = mul_a * mul_b;
   // both products fit in the lower bits
   assign prod  = mul_p[PROD_W-1:0];

   assign div_by_zero = (cfg.divisor == '0);
   assign div_start   = (state_ff == ST_MUL) && !div_by_zero;

   lsal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (cfg.divisor),
      .quotient (div_quo),
      .sts      (div_sts)
   );

   // range decision against the current and the next lower full scale
   assign fs_cur    = cfg.full_scale[range_ff];
   assign fs_below  = cfg.full_scale[range_ff - 1'b1];
   assign step_up   = (lux_ff >= {{(LUX_W-FS_W){1'b0}}, fs_cur}) && (range_ff != RANGE_TOP);
   assign step_down = (range_ff != RANGE_LOW) &&
                      (lux_ff < {{(LUX_W-FS_W){1'b0}}, fs_below});

   always_comb begin
      state_in         = state_ff;
      range_in         = range_ff;
      count_in         = count_ff;
      lux_in           = lux_ff;
      res_remeasure_in = res_remeasure_ff;
      res_lux_in       = res_lux_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_remeasure_in = rsp_remeasure_ff;
      rsp_range_in     = rsp_range_ff;
      rsp_lux_in       = rsp_lux_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               count_in = req_ch.adc_count;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // a zero divisor saturates lux without running the divider
            if (div_by_zero) begin
               lux_in   = LUX_MAX;
               state_in = ST_CMP;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               lux_in   = sat_lux(div_quo);
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            priority if (step_up) begin
               range_in         = range_ff + 1'b1;
               res_remeasure_in = 1'b1;
               res_lux_in       = '0;
               state_in         = ST_OUT;
            end else if (step_down) begin
               range_in         = range_ff - 1'b1;
               res_remeasure_in = 1'b1;
               res_lux_in       = '0;
               state_in         = ST_OUT;
            end else begin
               res_remeasure_in = 1'b0;
               state_in         = ST_CORR;
            end
         end
         ST_CORR: begin
            res_lux_in = sat_lux(prod);
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hand over once the response register is free or being emptied
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_remeasure_in = res_remeasure_ff;
               rsp_range_in     = range_ff;
               rsp_lux_in       = res_lux_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         range_ff     <= RANGE_LOW;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff         <= count_in;
      lux_ff           <= lux_in;
      res_remeasure_ff <= res_remeasure_in;
      res_lux_ff       <= res_lux_in;
      rsp_remeasure_ff <= rsp_remeasure_in;
      rsp_range_ff     <= rsp_range_in;
      rsp_lux_ff       <= rsp_lux_in;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.remeasure    = rsp_remeasure_ff;
   assign rsp_ch.active_range = rsp_range_ff;
   assign rsp_ch.lux_report   = rsp_lux_ff;

   `ASSERT_HOLDS(a_div_busy_in_div, div_sts.busy |-> (state_ff == ST_DIV),
      "divider busy outside the divide state")
   `ASSERT_HOLDS(a_remeasure_no_lux, (rsp_valid_ff && rsp_remeasure_ff) |-> (rsp_lux_ff == '0),
      "range change response carries a lux value")
   `ASSERT_HOLDS(a_range_single_step,
      (!$past(reset) && (range_ff != $past(range_ff))) |->
      ((range_ff == $past(range_ff) + 1'b1) || (range_ff == $past(range_ff) - 1'b1)),
      "range moved by more than one step")

endmodule

`default_nettype wire

// ===== sv/lsal_csr.sv =====
// configuration register file of the lux core
`default_nettype none

module lsal_csr import lsal_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output lsal_cfg_type               cfg
);

   lsal_cfg_type cfg_ff;
   lsal_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FS0:     cfg_in.full_scale[0] = csr_wdata[FS_W-1:0];
            CSR_FS1:     cfg_in.full_scale[1] = csr_wdata[FS_W-1:0];
            CSR_FS2:     cfg_in.full_scale[2] = csr_wdata[FS_W-1:0];
            CSR_FS3:     cfg_in.full_scale[3] = csr_wdata[FS_W-1:0];
            CSR_DIVISOR: cfg_in.divisor       = csr_wdata[DIV_W-1:0];
            CSR_CORR:    cfg_in.corr          = csr_wdata[CORR_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale[0] <= FS0_RESET;
         cfg_ff.full_scale[1] <= FS1_RESET;
         cfg_ff.full_scale[2] <= FS2_RESET;
         cfg_ff.full_scale[3] <= FS3_RESET;
         cfg_ff.divisor       <= DIV_RESET;
         cfg_ff.corr          <= CORR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/lsal_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"

module lsal_div import lsal_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]  divisor,
   output logic [PROD_W-1:0]      quotient,
   output div_sts_type            sts
);

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DIV_W:0]    shifted;
   logic [DIV_W+1:0]  diff;
   logic              fits;

   // partial remainder shifted left with the next dividend bit
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor_ff};
   assign fits    = !diff[DIV_W+1];

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in  = {quo_ff[PROD_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

   `ASSERT_NEXT(a_div_done_pulse, done_ff, !done_ff, "divider done held longer than one cycle")
   `ASSERT_HOLDS(a_div_no_restart, start |-> !busy_ff, "divider started while still busy")
   `ASSERT_HOLDS(a_div_rem_bound, (busy_ff && divisor_ff != '0) |-> (rem_ff < divisor_ff),
      "partial remainder not below divisor")

endmodule

`default_nettype wire
